// File: src/actc_pkg.sv
// ----------------------------------------------------------------------------
// actc_pkg
// Shared types and constants for the AR autocovariance Toeplitz unit.
// ----------------------------------------------------------------------------
package actc_pkg;

  localparam int unsigned NUM_PHI = 4;
  localparam int unsigned IDX_W   = 6;   // row / column / lag address width
  localparam int unsigned DIM_W   = 7;   // time_points width
  localparam int unsigned ORD_W   = 3;   // ar_order width
  localparam int unsigned CFG_W   = 16;  // widest register
  localparam int unsigned REG_W   = 3;   // register index width

  // register indexes
  localparam logic [REG_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [REG_W-1:0] REG_PHI0  = 3'd1;
  localparam logic [REG_W-1:0] REG_PHI1  = 3'd2;
  localparam logic [REG_W-1:0] REG_PHI2  = 3'd3;
  localparam logic [REG_W-1:0] REG_PHI3  = 3'd4;
  localparam logic [REG_W-1:0] REG_ORDER = 3'd5;
  localparam logic [REG_W-1:0] REG_TIME  = 3'd6;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_ROW   = 1'b1;

  localparam logic [32:0] ONE_Q30    = 33'h0_4000_0000;
  localparam logic [6:0]  FALLBACK_K = 7'd100;
  localparam int unsigned DIV_STEPS  = 31;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_SQUARE,
    OP_LAG0,
    OP_DIV_STEP,
    OP_LAG0_WR,
    OP_MUL,
    OP_ACC,
    OP_LAG_WR,
    OP_FINISH,
    OP_RD_ADDR,
    OP_RD_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       idx;
    logic [IDX_W-1:0] addr;
    logic [DIM_W-1:0] n;
    logic             first;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_run;
    logic out_done;
  } dp_stat_t;

endpackage

// File: src/actc_req_if.sv
// ----------------------------------------------------------------------------
// actc_req_if
// Request channel: rebuild or row read.
// ----------------------------------------------------------------------------
interface actc_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] row;

  modport source (output valid, output kind, output row, input ready);
  modport sink   (input valid, input kind, input row, output ready);
endinterface

// File: src/actc_rsp_if.sv
// ----------------------------------------------------------------------------
// actc_rsp_if
// Result channel: one covariance element per transfer.
// ----------------------------------------------------------------------------
interface actc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [5:0]         column;
  logic               last;
  logic               nonstationary;
  logic               saturated;

  modport source (output valid, output value, output column, output last,
                  output nonstationary, output saturated, input ready);
  modport sink   (input valid, input value, input column, input last,
                  input nonstationary, input saturated, output ready);
endinterface

// File: src/actc_datapath.sv
// ----------------------------------------------------------------------------
// actc_datapath
// Arithmetic, lag table memory and result register.
// ----------------------------------------------------------------------------
module actc_datapath #(
  parameter int unsigned MAX_TIME = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  actc_pkg::dp_cmd_t     cmd,
  output actc_pkg::dp_stat_t    stat,
  input  logic [15:0]           noise_sigma,
  input  logic signed [15:0]    phi [actc_pkg::NUM_PHI],
  actc_rsp_if.source            rsp
);
  import actc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TIME);

  logic [31:0]        sigma2;
  logic [32:0]        ssum;
  logic [31:0]        rem;
  logic [30:0]        quo;
  logic               div_run;
  logic signed [31:0] lag_val;
  logic signed [31:0] lag0;
  logic signed [31:0] win [NUM_PHI];
  logic signed [47:0] prod;
  logic signed [49:0] acc;
  logic               fallback;
  logic               clamp;
  logic [DIM_W-1:0]   built_n;
  logic [31:0]        lag_mem [MAX_TIME];
  logic [31:0]        mem_q;
  logic               rd_ok;

  logic [30:0]        den;
  logic [38:0]        big;
  logic [31:0]        trial;
  logic signed [34:0] rnd;
  logic signed [31:0] lag_k;
  logic               lag_k_clip;
  logic signed [31:0] l0_final;

  always_comb begin
    den   = 31'(ONE_Q30 - ssum);
    big   = sigma2 * FALLBACK_K;
    trial = {rem[30:0], cmd.first ? sigma2[0] : 1'b0};
    rnd   = 35'((acc + 50'sd16384) >>> 15);
    lag_k_clip = 1'b0;
    if (rnd > 35'sh0_7FFF_FFFF) begin
      lag_k = 32'sh7FFF_FFFF;
      lag_k_clip = 1'b1;
    end else if (rnd < -35'sh0_8000_0000) begin
      lag_k = 32'sh8000_0000;
      lag_k_clip = 1'b1;
    end else begin
      lag_k = rnd[31:0];
    end
    l0_final = div_run ? {1'b0, quo} : lag_val;
  end

  assign stat.div_run  = div_run;
  assign stat.out_done = rsp.valid & rsp.ready;

  // lag table memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LAG0_WR) begin
      lag_mem[0] <= l0_final;
    end else if (cmd.op == OP_LAG_WR) begin
      lag_mem[cmd.addr[AW-1:0]] <= lag_k;
    end
    if (cmd.op == OP_RD_ADDR) begin
      mem_q <= lag_mem[cmd.addr[AW-1:0]];
      rd_ok <= {1'b0, cmd.addr} < built_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback  <= 1'b0;
      clamp     <= 1'b0;
      built_n   <= '0;
      div_run   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (cmd.op)
        OP_INIT: begin
          sigma2 <= noise_sigma * noise_sigma;
          ssum   <= '0;
          clamp  <= 1'b0;
          for (int i = 0; i < NUM_PHI; i++) begin
            win[i] <= '0;
          end
        end
        OP_SQUARE: begin
          ssum <= ssum + 33'(32'(phi[cmd.idx] * phi[cmd.idx]));
        end
        OP_LAG0: begin
          if (ssum >= ONE_Q30) begin
            fallback <= 1'b1;
            div_run  <= 1'b0;
            if (big[38:31] != '0) begin
              lag_val <= 32'sh7FFF_FFFF;
              clamp   <= 1'b1;
            end else begin
              lag_val <= big[31:0];
            end
          end else begin
            fallback <= 1'b0;
            if (sigma2 >= {den, 1'b0}) begin
              lag_val <= 32'sh7FFF_FFFF;
              clamp   <= 1'b1;
              div_run <= 1'b0;
            end else begin
              rem     <= {1'b0, sigma2[31:1]};
              quo     <= '0;
              div_run <= 1'b1;
            end
          end
        end
        OP_DIV_STEP: begin
          if (trial >= {1'b0, den}) begin
            rem <= trial - {1'b0, den};
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[29:0], 1'b0};
          end
        end
        OP_LAG0_WR: begin
          lag0   <= l0_final;
          win[0] <= l0_final;
          acc    <= '0;
        end
        OP_MUL: begin
          prod <= phi[cmd.idx] * win[cmd.idx];
        end
        OP_ACC: begin
          acc <= acc + 50'(prod);
        end
        OP_LAG_WR: begin
          if (lag_k_clip) begin
            clamp <= 1'b1;
          end
          win[0] <= lag_k;
          for (int i = 1; i < NUM_PHI; i++) begin
            win[i] <= win[i-1];
          end
          acc <= '0;
        end
        OP_FINISH: begin
          built_n       <= cmd.n;
          rsp.valid     <= 1'b1;
          rsp.value     <= lag0;
          rsp.column    <= '0;
          rsp.last      <= 1'b1;
          rsp.nonstationary <= fallback;
          rsp.saturated <= clamp;
        end
        OP_RD_LOAD: begin
          rsp.valid     <= 1'b1;
          rsp.value     <= rd_ok ? mem_q : '0;
          rsp.column    <= cmd.addr;
          rsp.last      <= cmd.last;
          rsp.nonstationary <= fallback;
          rsp.saturated <= clamp;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/actc_ctrl.sv
// ----------------------------------------------------------------------------
// actc_ctrl
// Sequencer: rebuild steps and row sweep, issuing datapath commands.
// ----------------------------------------------------------------------------
module actc_ctrl #(
  parameter int unsigned MAX_TIME  = 64,
  parameter int unsigned MAX_ORDER = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  actc_req_if.sink                      req,
  input  logic [actc_pkg::ORD_W-1:0]    ar_order,
  input  logic [actc_pkg::DIM_W-1:0]    time_points,
  output actc_pkg::dp_cmd_t             cmd,
  input  actc_pkg::dp_stat_t            stat
);
  import actc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SQ, S_LAG0, S_CHECK, S_DIV, S_L0WR,
    S_MUL, S_ACC, S_LAGWR, S_FIN, S_RADDR, S_RLOAD, S_OWAIT
  } state_t;

  state_t           state;
  logic             kind;
  logic [IDX_W-1:0] row;
  logic [ORD_W-1:0] j;
  logic [DIM_W-1:0] k;
  logic [DIM_W-1:0] col;
  logic [4:0]       dcnt;
  logic [ORD_W-1:0] p;
  logic [DIM_W-1:0] n;
  logic [IDX_W-1:0] c6;
  logic [IDX_W-1:0] lag_d;

  always_comb begin
    p = (ar_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ar_order;
    if (time_points == '0) begin
      n = DIM_W'(1);
    end else if (time_points > DIM_W'(MAX_TIME)) begin
      n = DIM_W'(MAX_TIME);
    end else begin
      n = time_points;
    end
    c6    = col[IDX_W-1:0];
    lag_d = (row > c6) ? row - c6 : c6 - row;
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.idx   = j[1:0];
    cmd.n     = n;
    cmd.first = (dcnt == 5'(DIV_STEPS - 1));
    unique case (state)
      S_INIT:  cmd.op = OP_INIT;
      S_SQ:    cmd.op = (j < p) ? OP_SQUARE : OP_NONE;
      S_LAG0:  cmd.op = OP_LAG0;
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_L0WR:  cmd.op = OP_LAG0_WR;
      S_MUL:   cmd.op = (j < p) ? OP_MUL : OP_NONE;
      S_ACC:   cmd.op = OP_ACC;
      S_LAGWR: begin
        cmd.op   = OP_LAG_WR;
        cmd.addr = k[IDX_W-1:0];
      end
      S_FIN:   cmd.op = OP_FINISH;
      S_RADDR: begin
        cmd.op   = OP_RD_ADDR;
        cmd.addr = lag_d;
      end
      S_RLOAD: begin
        cmd.op   = OP_RD_LOAD;
        cmd.addr = c6;
        cmd.last = (col + DIM_W'(1) == n);
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      k     <= '0;
      col   <= '0;
      dcnt  <= '0;
      kind  <= KIND_BUILD;
      row   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind <= req.kind;
            row  <= req.row;
            col  <= '0;
            if (req.kind == KIND_BUILD) begin
              state <= S_INIT;
            end else if ({1'b0, req.row} < n) begin
              state <= S_RADDR;
            end
          end
        end
        S_INIT: begin
          j     <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (j < p) begin
            j <= j + ORD_W'(1);
          end else begin
            state <= S_LAG0;
          end
        end
        S_LAG0:  state <= S_CHECK;
        S_CHECK: begin
          dcnt  <= 5'(DIV_STEPS - 1);
          state <= stat.div_run ? S_DIV : S_L0WR;
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_L0WR;
          end else begin
            dcnt <= dcnt - 5'd1;
          end
        end
        S_L0WR: begin
          k     <= DIM_W'(1);
          j     <= '0;
          state <= (n == DIM_W'(1)) ? S_FIN : S_MUL;
        end
        S_MUL: begin
          state <= (j < p) ? S_ACC : S_LAGWR;
        end
        S_ACC: begin
          j     <= j + ORD_W'(1);
          state <= S_MUL;
        end
        S_LAGWR: begin
          k     <= k + DIM_W'(1);
          j     <= '0;
          state <= (k + DIM_W'(1) == n) ? S_FIN : S_MUL;
        end
        S_FIN:   state <= S_OWAIT;
        S_RADDR: state <= S_RLOAD;
        S_RLOAD: state <= S_OWAIT;
        S_OWAIT: begin
          if (stat.out_done) begin
            if (kind == KIND_BUILD || col + DIM_W'(1) == n) begin
              state <= S_IDLE;
            end else begin
              col   <= col + DIM_W'(1);
              state <= S_RADDR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/ar_autocovariance_toeplitz_unit.sv
// ----------------------------------------------------------------------------
// ar_autocovariance_toeplitz_unit
// AR(p) autocovariance table builder and Toeplitz covariance row server.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | transfer
//  req     | in  | kind, row                                        | valid & ready
//  rsp     | out | value, column, last, nonstationary, saturated    | valid & ready
//  config  | in  | write_en, reg_index, write_data                  | write_en
//
//  One item at a time. Rebuild: square sum of the p coefficients, lag 0
//  from the restoring divider (skipped on fallback or clamp), then a
//  multiply-accumulate per further lag up to n - 1, then the result
//  transfer. Row read: per element a memory read, a result load and a
//  transfer. Reset is synchronous; the lag table reads as zero until the
//  first rebuild. A stalled rsp holds the sequencer in place.
// ----------------------------------------------------------------------------
module ar_autocovariance_toeplitz_unit #(
  parameter int unsigned MAX_TIME  = 64,
  parameter int unsigned MAX_ORDER = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  actc_req_if.sink                      req,
  actc_rsp_if.source                    rsp,
  input  logic                          write_en,
  input  logic [actc_pkg::REG_W-1:0]    reg_index,
  input  logic [actc_pkg::CFG_W-1:0]    write_data
);
  import actc_pkg::*;

  logic [15:0]        noise_sigma;
  logic signed [15:0] phi [NUM_PHI];
  logic [ORD_W-1:0]   ar_order;
  logic [DIM_W-1:0]   time_points;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_sigma <= 16'd256;
      for (int i = 0; i < NUM_PHI; i++) begin
        phi[i] <= '0;
      end
      ar_order    <= ORD_W'(1);
      time_points <= DIM_W'(64);
    end else if (write_en) begin
      unique case (reg_index)
        REG_SIGMA: noise_sigma <= write_data;
        REG_PHI0:  phi[0] <= write_data;
        REG_PHI1:  phi[1] <= write_data;
        REG_PHI2:  phi[2] <= write_data;
        REG_PHI3:  phi[3] <= write_data;
        REG_ORDER: ar_order <= write_data[ORD_W-1:0];
        REG_TIME:  time_points <= write_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  actc_ctrl #(
    .MAX_TIME  (MAX_TIME),
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .ar_order    (ar_order),
    .time_points (time_points),
    .cmd         (cmd),
    .stat        (stat)
  );

  actc_datapath #(
    .MAX_TIME (MAX_TIME)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .noise_sigma (noise_sigma),
    .phi         (phi),
    .rsp         (rsp)
  );

endmodule
